[rtl/core/mtc_pkg.sv]
// Package for the metatile column composer: payload types, codes and constants.
`default_nettype none

package mtc_pkg;

    // Default size of the metatile tables
    localparam int METATILE_COUNT_DEF = 256;

    // Step sequence of one column: 56 tile steps, then 8 attribute steps
    localparam int ROWS       = 14;
    localparam int HALF_SLOTS = 28;
    localparam int TILE_SLOTS = 56;
    localparam int LAST_STEP  = 63;

    // Item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_BWD  = 2'd2;

    // Result kinds
    localparam logic KIND_TILE = 1'b0;
    localparam logic KIND_ATTR = 1'b1;

    // Tile select codes: {lower, right}
    localparam logic [1:0] SEL_UL = 2'b00;
    localparam logic [1:0] SEL_UR = 2'b01;
    localparam logic [1:0] SEL_LL = 2'b10;
    localparam logic [1:0] SEL_LR = 2'b11;

    // Attribute masks
    localparam logic [7:0] KEEP_FWD  = 8'h33;
    localparam logic [7:0] KEEP_BWD  = 8'hCC;
    localparam logic [7:0] KEEP_NONE = 8'h00;
    localparam logic [7:0] ATTR_PIN  = 8'h0F;

    // Request item
    typedef struct packed {
        logic [1:0]  mode;
        logic        column_present;
        logic [55:0] metatiles_top;
        logic [55:0] metatiles_bottom;
        logic [7:0]  table_index;
        logic [7:0]  tile_upper_left;
        logic [7:0]  tile_upper_right;
        logic [7:0]  tile_lower_left;
        logic [7:0]  tile_lower_right;
        logic [1:0]  palette;
    } req_t;

    // Result item
    typedef struct packed {
        logic       kind;
        logic [5:0] slot;
        logic [7:0] value;
        logic       last;
    } rsp_t;

    // One metatile table entry
    typedef struct packed {
        logic [7:0] ul;
        logic [7:0] ur;
        logic [7:0] ll;
        logic [7:0] lr;
        logic [1:0] pal;
    } entry_t;

    // Decoded step, from sequencer to emit stage
    typedef struct packed {
        logic       kind;
        logic [5:0] slot;
        logic [1:0] tile_sel;
        logic       oor;
        logic       pal_op;
        logic [2:0] abyte;
        logic [1:0] sh;
        logic       first;
        logic [7:0] keep;
        logic       last;
    } step_t;

endpackage

`default_nettype wire

[rtl/core/mtc_tables.sv]
// Metatile table memory: tile codes and palette per entry, registered read.
`default_nettype none

module mtc_tables #(
    parameter int METATILE_COUNT = mtc_pkg::METATILE_COUNT_DEF,
    localparam int AW = $clog2(METATILE_COUNT)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire mtc_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output mtc_pkg::entry_t      rd_data
);

    mtc_pkg::entry_t mem [METATILE_COUNT];
    mtc_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered, held while stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/mtc_seq.sv]
// Sequencer: takes items, performs loads, steps through a column and issues table reads.
`default_nettype none

module mtc_seq #(
    parameter int METATILE_COUNT = mtc_pkg::METATILE_COUNT_DEF,
    localparam int AW = $clog2(METATILE_COUNT)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire mtc_pkg::req_t   req,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire logic            adv,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output mtc_pkg::entry_t      wr_data,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    output mtc_pkg::step_t       p1,
    output logic                 p1_valid
);

    // control state
    logic       busy_reg,   busy_next;
    logic [5:0] cnt_reg,    cnt_next;
    logic       first_reg,  first_next;
    logic       parity_reg, parity_next;
    logic       fix_reg;
    logic       bwd_reg;
    logic       ap_reg;
    logic       p1_valid_reg;

    // payload state
    logic [55:0]     top_reg;
    logic [55:0]     bot_reg;
    mtc_pkg::step_t  p1_reg;
    mtc_pkg::step_t  step;

    logic       last_issue;
    logic       acc;
    logic       is_build;
    logic       bwd_n;
    logic       ap_n;

    logic       tile;
    logic       half;
    logic [5:0] t6;
    logic [3:0] row;
    logic [2:0] row_b;
    logic       right;
    logic       upper;
    logic       odd;
    logic [4:0] rp1;
    logic [7:0] m;

    // handshake
    assign last_issue = busy_reg && (cnt_reg == 6'(mtc_pkg::LAST_STEP));
    assign req_ready  = !busy_reg || (adv && last_issue);
    assign acc        = req_valid && req_ready;
    assign is_build   = req.mode inside {mtc_pkg::MODE_FWD, mtc_pkg::MODE_BWD};
    assign bwd_n      = (req.mode == mtc_pkg::MODE_BWD);
    assign ap_n       = bwd_n ? (~parity_reg ^ fix_reg) : ~parity_reg;

    // table load
    assign wr_en   = acc && (req.mode == mtc_pkg::MODE_LOAD)
                     && ({1'b0, req.table_index} < 9'(METATILE_COUNT));
    assign wr_addr = req.table_index[AW-1:0];
    assign wr_data = '{ul:  req.tile_upper_left,
                       ur:  req.tile_upper_right,
                       ll:  req.tile_lower_left,
                       lr:  req.tile_lower_right,
                       pal: req.palette};

    // step counter
    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        parity_next = parity_reg;
        if (adv && busy_reg)
        begin
            first_next = 1'b0;
            if (last_issue)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
            end
        end
        if (acc && is_build)
        begin
            busy_next   = 1'b1;
            cnt_next    = req.column_present ? 6'd0 : 6'(mtc_pkg::TILE_SLOTS);
            first_next  = 1'b1;
            parity_next = ~parity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            first_reg    <= 1'b0;
            parity_reg   <= 1'b1;
            fix_reg      <= 1'b0;
            bwd_reg      <= 1'b0;
            ap_reg       <= 1'b0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            parity_reg <= parity_next;
            if (cfg_we)
            begin
                fix_reg <= cfg_wdata;
            end
            if (acc && is_build)
            begin
                bwd_reg <= bwd_n;
                ap_reg  <= ap_n;
            end
            if (adv)
            begin
                p1_valid_reg <= busy_reg;
            end
        end
    end

    // column metatiles, captured with each build
    always_ff @(posedge clk)
    begin
        if (acc && is_build)
        begin
            top_reg <= req.metatiles_top;
            bot_reg <= req.metatiles_bottom;
        end
    end

    // decode the current step
    assign tile  = (cnt_reg < 6'(mtc_pkg::TILE_SLOTS));
    assign half  = (cnt_reg >= 6'(mtc_pkg::HALF_SLOTS));
    assign t6    = half ? (cnt_reg - 6'(mtc_pkg::HALF_SLOTS)) : cnt_reg;
    assign row   = t6[4:1];
    assign row_b = 3'(row - 4'd7);
    assign right = t6[0];
    assign upper = bwd_reg ? half : !half;
    assign odd   = bwd_reg ? ~row[0] : row[0];
    assign rp1   = {1'b0, row} + 5'd1;
    assign m     = (row < 4'd7) ? top_reg[{row[2:0], 3'b000} +: 8]
                                : bot_reg[{row_b, 3'b000} +: 8];

    always_comb
    begin
        step          = '0;
        step.kind     = tile ? mtc_pkg::KIND_TILE : mtc_pkg::KIND_ATTR;
        step.slot     = tile ? cnt_reg : {3'b000, cnt_reg[2:0]};
        step.tile_sel = {~upper, right};
        step.oor      = ({1'b0, m} >= 9'(METATILE_COUNT));
        step.pal_op   = tile && !half && !right;
        step.abyte    = tile ? rp1[3:1] : cnt_reg[2:0];
        step.first    = first_reg;
        step.last     = (cnt_reg == 6'(mtc_pkg::LAST_STEP));
        // palette position within its attribute byte
        if (bwd_reg)
        begin
            step.sh   = ap_reg ? (odd ? 2'd2 : 2'd0) : (odd ? 2'd3 : 2'd1);
            step.keep = ap_reg ? mtc_pkg::KEEP_BWD : mtc_pkg::KEEP_NONE;
        end
        else
        begin
            step.sh   = ap_reg ? (odd ? 2'd1 : 2'd3) : (odd ? 2'd0 : 2'd2);
            step.keep = ap_reg ? mtc_pkg::KEEP_FWD : mtc_pkg::KEEP_NONE;
        end
    end

    // table read runs alongside the step register
    assign rd_en   = adv && busy_reg;
    assign rd_addr = m[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= step;
        end
    end

    assign p1       = p1_reg;
    assign p1_valid = p1_valid_reg;

endmodule

`default_nettype wire

[rtl/core/mtc_emit.sv]
// Emit stage: attribute store update, result value select and output register.
`default_nettype none

module mtc_emit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtc_pkg::step_t  p1,
    input  wire logic            p1_valid,
    input  wire mtc_pkg::entry_t rd_data,
    output logic                 adv,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output mtc_pkg::rsp_t        rsp
);

    logic [7:0]    attr_reg [8];
    logic [7:0]    attr_mid [8];
    logic [7:0]    attr_new [8];
    logic          rsp_valid_reg;
    mtc_pkg::rsp_t rsp_reg;
    mtc_pkg::rsp_t rsp_next;
    logic [1:0]    pal;
    logic [7:0]    tile_val;

    // pipeline moves when the output register is free or being taken
    assign adv = !rsp_valid_reg || rsp_ready;

    assign pal = p1.oor ? 2'd0 : rd_data.pal;

    // mask and pin on the first step, then merge the row palette
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            attr_mid[i] = attr_reg[i];
            if (p1_valid && p1.first)
            begin
                attr_mid[i] = attr_reg[i] & p1.keep;
            end
        end
        if (p1_valid && p1.first)
        begin
            attr_mid[0] = attr_mid[0] | mtc_pkg::ATTR_PIN;
        end
        for (int i = 0; i < 8; i++)
        begin
            attr_new[i] = attr_mid[i];
        end
        if (p1_valid && p1.pal_op)
        begin
            attr_new[p1.abyte] = attr_mid[p1.abyte] | (8'(pal) << {p1.sh, 1'b0});
        end
    end

    // tile code select
    always_comb
    begin
        case (p1.tile_sel)
            mtc_pkg::SEL_UL: tile_val = rd_data.ul;
            mtc_pkg::SEL_UR: tile_val = rd_data.ur;
            mtc_pkg::SEL_LL: tile_val = rd_data.ll;
            mtc_pkg::SEL_LR: tile_val = rd_data.lr;
            default:         tile_val = '0;
        endcase
        if (p1.oor)
        begin
            tile_val = '0;
        end
    end

    always_comb
    begin
        rsp_next.kind  = p1.kind;
        rsp_next.slot  = p1.slot;
        rsp_next.value = (p1.kind == mtc_pkg::KIND_TILE) ? tile_val : attr_mid[p1.abyte];
        rsp_next.last  = p1.last;
    end

    // attribute store and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                attr_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            rsp_valid_reg <= p1_valid;
            for (int i = 0; i < 8; i++)
            begin
                attr_reg[i] <= attr_new[i];
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/core/metatile_column_composer.sv]
// A build's first result passes the step register and table read, then the output register.
// Throughput: one result per cycle from the step counter unless the output stalls;
// a present column issues 64 steps, an absent one 8, a load or an unused mode none;
// the next item is taken in the cycle the previous column issues its last step.
// Reset: rst_n clears the attribute store, the parity to one and parity_fix to zero;
// the metatile tables are not cleared and need no clearing pass.
`default_nettype none

module metatile_column_composer #(
    parameter int METATILE_COUNT = mtc_pkg::METATILE_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mtc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mtc_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata
);

    localparam int AW = $clog2(METATILE_COUNT);

    logic            adv;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    mtc_pkg::entry_t wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    mtc_pkg::entry_t rd_data;
    mtc_pkg::step_t  p1;
    logic            p1_valid;

    // item intake and step sequencing
    mtc_seq #(
        .METATILE_COUNT(METATILE_COUNT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .adv      (adv),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .p1       (p1),
        .p1_valid (p1_valid)
    );

    // metatile tables
    mtc_tables #(
        .METATILE_COUNT(METATILE_COUNT)
    ) u_tables (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // attribute store and results
    mtc_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .p1       (p1),
        .p1_valid (p1_valid),
        .rd_data  (rd_data),
        .adv      (adv),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

[rtl/core/mtc_checker.sv]
// Port checker for the metatile column composer, bound to the top level.
`default_nettype none

module mtc_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire mtc_pkg::rsp_t rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // the column ends on attribute byte seven
    a_last_attr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |-> (rsp.kind == mtc_pkg::KIND_ATTR) && (rsp.slot == 6'd7))
        else $error("last flag on a result other than attribute byte seven");

    // attribute results index one of eight bytes
    a_attr_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == mtc_pkg::KIND_ATTR) |-> (rsp.slot <= 6'd7))
        else $error("attribute slot out of range");

    // tile results never carry the last flag and stay inside the buffer
    a_tile_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == mtc_pkg::KIND_TILE)
        |-> !rsp.last && (rsp.slot <= 6'd55))
        else $error("bad tile result");

endmodule

bind metatile_column_composer mtc_checker u_mtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the metatile column composer.
`timescale 1ns / 100ps

// Tracks table, attribute and parity state and holds the results still to come
class column_checker;
    logic [7:0] ul_codes [256];
    logic [7:0] ur_codes [256];
    logic [7:0] ll_codes [256];
    logic [7:0] lr_codes [256];
    logic [1:0] pal_codes [256];
    logic [7:0] attr_bytes [8];
    bit parity;
    bit parity_fix;
    mtc_pkg::rsp_t expected_bytes [$];
    int error_count;
    int checked_count;

    function new();
        foreach (attr_bytes[j])
            attr_bytes[j] = 8'h00;
        parity = 1'b1;
        parity_fix = 1'b0;
        error_count = 0;
        checked_count = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function void push_result(logic kind, int slot, logic [7:0] value, bit last);
        mtc_pkg::rsp_t r;
        r.kind = kind;
        r.slot = 6'(slot);
        r.value = value;
        r.last = last;
        expected_bytes.push_back(r);
    endfunction

    // Apply one accepted item and queue the results it causes
    function void note_item(mtc_pkg::req_t item);
        logic [7:0] tiles [mtc_pkg::TILE_SLOTS];
        logic [7:0] keep;
        logic [7:0] meta;
        logic [7:0] pal_byte;
        bit backward;
        bit half;
        int sh_even;
        int sh_odd;
        int sh;
        int row;
        int aidx;
        int base;
        if (item.mode == mtc_pkg::MODE_LOAD)
        begin
            ul_codes[item.table_index] = item.tile_upper_left;
            ur_codes[item.table_index] = item.tile_upper_right;
            ll_codes[item.table_index] = item.tile_lower_left;
            lr_codes[item.table_index] = item.tile_lower_right;
            pal_codes[item.table_index] = item.palette;
            return;
        end
        // unused mode: nothing changes
        if (item.mode != mtc_pkg::MODE_FWD && item.mode != mtc_pkg::MODE_BWD)
            return;

        // parity toggle and attribute half selection
        backward = (item.mode == mtc_pkg::MODE_BWD);
        parity = ~parity;
        half = backward ? (parity ^ parity_fix) : parity;
        if (backward)
        begin
            keep = half ? mtc_pkg::KEEP_BWD : mtc_pkg::KEEP_NONE;
            sh_even = half ? 0 : 1;
            sh_odd = half ? 2 : 3;
        end
        else
        begin
            keep = half ? mtc_pkg::KEEP_FWD : mtc_pkg::KEEP_NONE;
            sh_even = half ? 3 : 2;
            sh_odd = half ? 1 : 0;
        end
        foreach (attr_bytes[j])
            attr_bytes[j] &= keep;
        attr_bytes[0] |= mtc_pkg::ATTR_PIN;

        // tiles and palettes of a present column
        if (item.column_present)
        begin
            for (int i = 0; i < mtc_pkg::ROWS; i++)
            begin
                row = backward ? (mtc_pkg::ROWS - 1 - i) : i;
                if (row < mtc_pkg::ROWS / 2)
                    meta = item.metatiles_top[8 * row +: 8];
                else
                    meta = item.metatiles_bottom[8 * (row - mtc_pkg::ROWS / 2) +: 8];
                sh = (i % 2 == 1) ? sh_odd : sh_even;
                aidx = backward ? 7 - (i + 1) / 2 : (i + 1) / 2;
                pal_byte = {6'd0, pal_codes[meta]};
                attr_bytes[aidx] |= pal_byte << (2 * sh);
                base = 2 * i;
                if (backward)
                begin
                    tiles[mtc_pkg::TILE_SLOTS - 2 - base] = ul_codes[meta];
                    tiles[mtc_pkg::TILE_SLOTS - 1 - base] = ur_codes[meta];
                    tiles[mtc_pkg::HALF_SLOTS - 2 - base] = ll_codes[meta];
                    tiles[mtc_pkg::HALF_SLOTS - 1 - base] = lr_codes[meta];
                end
                else
                begin
                    tiles[base] = ul_codes[meta];
                    tiles[base + 1] = ur_codes[meta];
                    tiles[mtc_pkg::HALF_SLOTS + base] = ll_codes[meta];
                    tiles[mtc_pkg::HALF_SLOTS + base + 1] = lr_codes[meta];
                end
            end
            for (int s = 0; s < mtc_pkg::TILE_SLOTS; s++)
                push_result(mtc_pkg::KIND_TILE, s, tiles[s], 1'b0);
        end
        for (int j = 0; j < 8; j++)
            push_result(mtc_pkg::KIND_ATTR, j, attr_bytes[j], j == 7);
    endfunction

    task report(string what);
        if (error_count < 200)
            $display("mismatch at result %0d: %s", checked_count, what);
        error_count++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(mtc_pkg::rsp_t got);
        mtc_pkg::rsp_t want;
        checked_count++;
        if (expected_bytes.size() == 0)
        begin
            report($sformatf("unexpected result kind=%0d slot=%0d value=%02h last=%0d",
                             got.kind, got.slot, got.value, got.last));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.slot !== want.slot)
            report($sformatf("slot got %0d want %0d", got.slot, want.slot));
        if (got.value !== want.value)
            report($sformatf("value got %02h want %02h (slot %0d kind %0d)",
                             got.value, want.value, want.slot, want.kind));
        if (got.last !== want.last)
            report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
endclass

module testbench;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int RANDOM_PHASES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    mtc_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    mtc_pkg::rsp_t rsp;
    logic cfg_we;
    logic cfg_wdata;

    column_checker composer_model = new();
    int cycle_count = 0;
    int hold_count = 0;
    bit loaded_map [256];
    logic [7:0] loaded_list [$];

    metatile_column_composer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check accepted results, stall at random, one long hold on request
    initial
    begin : result_sink
        int run_left;
        int hold_left;
        int hold_seen;
        int pick;
        bit ready_next;
        rsp_ready = 1'b0;
        run_left = 0;
        hold_left = 0;
        hold_seen = 0;
        ready_next = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
                composer_model.check_result(rsp);
            if (hold_count != hold_seen)
            begin
                hold_seen = hold_count;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                    begin
                        ready_next = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end
                    else if (pick < 62)
                    begin
                        ready_next = 1'b1;
                        run_left = $urandom_range(40, 150);
                    end
                    else if (pick < 95)
                    begin
                        ready_next = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        ready_next = 1'b0;
                        run_left = $urandom_range(8, 30);
                    end
                end
                run_left--;
            end
            rsp_ready <= ready_next;
        end
    end

    function automatic logic [55:0] random_wide();
        return 56'({$urandom, $urandom});
    endfunction

    // Seven rows of metatile indices drawn from loaded entries, random if none is loaded
    function automatic logic [55:0] loaded_rows();
        logic [55:0] v;
        if (loaded_list.size() == 0)
            return random_wide();
        for (int r = 0; r < mtc_pkg::ROWS / 2; r++)
            v[8 * r +: 8] = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        return v;
    endfunction

    function automatic mtc_pkg::req_t random_item();
        mtc_pkg::req_t it;
        int pick;
        it.column_present = 1'($urandom);
        it.metatiles_top = random_wide();
        it.metatiles_bottom = random_wide();
        it.table_index = 8'($urandom);
        it.tile_upper_left = 8'($urandom);
        it.tile_upper_right = 8'($urandom);
        it.tile_lower_left = 8'($urandom);
        it.tile_lower_right = 8'($urandom);
        it.palette = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            it.mode = mtc_pkg::MODE_LOAD;
        else if (pick < 95)
        begin
            it.mode = $urandom_range(0, 1) ? mtc_pkg::MODE_FWD : mtc_pkg::MODE_BWD;
            it.column_present = (pick < 85);
            if (it.column_present)
            begin
                it.metatiles_top = loaded_rows();
                it.metatiles_bottom = loaded_rows();
            end
        end
        else
            it.mode = MODE_UNUSED;
        return it;
    endfunction

    function automatic mtc_pkg::req_t load_item(logic [7:0] idx, logic [7:0] ul,
                                                logic [7:0] ur, logic [7:0] ll,
                                                logic [7:0] lr, logic [1:0] pal);
        mtc_pkg::req_t it;
        it = random_item();
        it.mode = mtc_pkg::MODE_LOAD;
        it.table_index = idx;
        it.tile_upper_left = ul;
        it.tile_upper_right = ur;
        it.tile_lower_left = ll;
        it.tile_lower_right = lr;
        it.palette = pal;
        return it;
    endfunction

    function automatic mtc_pkg::req_t column_item(logic [1:0] mode, logic present,
                                                  logic [55:0] top, logic [55:0] bottom);
        mtc_pkg::req_t it;
        it = random_item();
        it.mode = mode;
        it.column_present = present;
        it.metatiles_top = top;
        it.metatiles_bottom = bottom;
        return it;
    endfunction

    // Random gap before an item: mostly none or short, a few long
    task automatic sender_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(6, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one item and hold it until accepted
    task automatic offer_item(mtc_pkg::req_t item);
        sender_gap();
        if (item.mode == mtc_pkg::MODE_LOAD && !loaded_map[item.table_index])
        begin
            loaded_map[item.table_index] = 1'b1;
            loaded_list.push_back(item.table_index);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        composer_model.note_item(item);
    endtask

    // Stop offering until every queued result has come back
    task automatic pause_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (composer_model.pending() != 0)
            @(posedge clk);
    endtask

    // Drained, then a settling wait so a trailing load or unused item is done
    task automatic settle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_parity_fix(bit v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        composer_model.parity_fix = v;
    endtask

    initial
    begin
        mtc_pkg::req_t item;
        int issued;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_parity_fix(1'b0);

        // Directed: extreme codes and palettes, both directions, absent and unused
        offer_item(load_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
        offer_item(load_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3));
        offer_item(load_item(8'h55, 8'h12, 8'h34, 8'h56, 8'h78, 2'd1));
        offer_item(load_item(8'hAA, 8'h9A, 8'hBC, 8'hDE, 8'hF0, 2'd2));
        offer_item(column_item(mtc_pkg::MODE_FWD, 1'b1, '1, '1));
        offer_item(column_item(mtc_pkg::MODE_FWD, 1'b1, '0, '0));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b1, 56'h55AA55AA55AA55,
                               56'hAA55AA55AA55AA));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b1, '1, '1));
        offer_item(column_item(mtc_pkg::MODE_FWD, 1'b0, '1, '1));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b0, '0, '1));
        offer_item(column_item(MODE_UNUSED, 1'b1, '1, '1));
        offer_item(column_item(mtc_pkg::MODE_FWD, 1'b1, 56'h55AA55AA55AA55,
                               56'hAA55AA55AA55AA));
        offer_item(load_item(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
        offer_item(column_item(mtc_pkg::MODE_FWD, 1'b1, '1, '1));
        settle();

        // Directed with the odd-width parity flip
        write_parity_fix(1'b1);
        offer_item(load_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b1, '1, '1));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b1, 56'hAA55AA55AA55AA,
                               56'h55AA55AA55AA55));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b0, '1, '0));
        offer_item(column_item(mtc_pkg::MODE_FWD, 1'b1, 56'h55AA55AA55AA55,
                               56'hAA55AA55AA55AA));
        offer_item(column_item(mtc_pkg::MODE_BWD, 1'b1, '0, '0));
        settle();

        // Random phases, parity fix alternating; one long result-side hold
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_parity_fix(p % 2 == 1);
            if (p == 1)
                hold_count++;
            issued = 0;
            while (issued < ITEMS_PER_PHASE)
            begin
                item = random_item();
                if ($urandom_range(0, 59) == 0)
                    pause_until_drained();
                offer_item(item);
                if (item.mode != MODE_UNUSED)
                    issued++;
            end
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (composer_model.error_count == 0 && composer_model.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[files.f]
rtl/core/mtc_pkg.sv
rtl/core/mtc_tables.sv
rtl/core/mtc_seq.sv
rtl/core/mtc_emit.sv
rtl/core/metatile_column_composer.sv
rtl/core/mtc_checker.sv
dv/testbench.sv
